// ===== rtl/can_bus_state_manager_defines.svh =====
// Assertion macros for the CAN bus state manager.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef CAN_BUS_STATE_MANAGER_DEFINES_SVH
`define CAN_BUS_STATE_MANAGER_DEFINES_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define CBSM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// The condition must never be true outside reset.
`define CBSM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define CBSM_ASSERT(lbl, clk, rst_n, prop)
`define CBSM_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/cbsm_pkg.sv =====
// Shared types, codes and constants of the CAN bus state manager.
// No dependencies; used by the interfaces, the core and the top level.
`default_nettype none

package cbsm_pkg;

    localparam int unsigned NUM_CONTROLLERS = 1;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_TICKS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS    = 1'd1;

    localparam logic [15:0] RECOVERY_TICKS_RST = 16'd10;
    localparam logic [7:0]  MAX_ATTEMPTS_RST   = 8'd3;

    // Event kinds.
    localparam logic [2:0] OP_INIT    = 3'd0;
    localparam logic [2:0] OP_DEINIT  = 3'd1;
    localparam logic [2:0] OP_MODE    = 3'd2;
    localparam logic [2:0] OP_BUSOFF  = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    // Bus states.
    localparam logic [2:0] ST_UNINIT    = 3'd0;
    localparam logic [2:0] ST_PRE_NOCOM = 3'd1;
    localparam logic [2:0] ST_NOCOM     = 3'd2;
    localparam logic [2:0] ST_PRE_FULL  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_RECOVERY  = 3'd5;

    // Result codes.
    localparam logic [2:0] RC_OK       = 3'd0;
    localparam logic [2:0] RC_REFUSED  = 3'd1;
    localparam logic [2:0] RC_UNINIT   = 3'd2;
    localparam logic [2:0] RC_BAD_NET  = 3'd3;
    localparam logic [2:0] RC_BAD_CTRL = 3'd4;

    // Controller commands.
    localparam logic [1:0] CMD_NONE       = 2'd0;
    localparam logic [1:0] CMD_STOP       = 2'd1;
    localparam logic [1:0] CMD_START      = 2'd2;
    localparam logic [1:0] CMD_STOP_START = 2'd3;

    // Controller mode indications.
    localparam logic [1:0] LINK_NONE    = 2'd0;
    localparam logic [1:0] LINK_STOPPED = 2'd1;
    localparam logic [1:0] LINK_STARTED = 2'd2;

    // Communication mode indications.
    localparam logic [1:0] MGR_NONE  = 2'd0;
    localparam logic [1:0] MGR_FULL  = 2'd1;
    localparam logic [1:0] MGR_NOCOM = 2'd2;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;
    localparam logic [7:0]  COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] network_handle;
        logic       want_full;
        logic [7:0] controller_index;
        logic       controller_ok;
    } req_t;

    typedef struct packed {
        logic [2:0] result_code;
        logic [2:0] bus_state;
        logic       full_com;
        logic [1:0] controller_cmd;
        logic [1:0] link_indication;
        logic [1:0] manager_indication;
        logic [7:0] attempt_count;
    } rsp_t;

    typedef struct packed {
        logic        initialized;
        logic [2:0]  bsm_state;
        logic        com_full;
        logic        busoff_pending;
        logic [15:0] recovery_timer;
        logic [7:0]  recovery_count;
    } state_t;

    typedef struct packed {
        logic [15:0] recovery_ticks;
        logic [7:0]  max_recovery_attempts;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/cbsm_req_if.sv =====
// Event request channel of the CAN bus state manager: valid, ready and payload.
// Depends on cbsm_pkg for the payload type.
`default_nettype none

interface cbsm_req_if
    import cbsm_pkg::*;
;
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/cbsm_rsp_if.sv =====
// Result channel of the CAN bus state manager: valid, ready and payload.
// Depends on cbsm_pkg for the payload type.
`default_nettype none

interface cbsm_rsp_if
    import cbsm_pkg::*;
;
    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/can_bus_state_manager.sv =====
// Top level of the CAN bus state manager: input register, event logic, result register.
// Depends on cbsm_pkg, cbsm_req_if, cbsm_rsp_if, cbsm_core and the assertion macros.
//
// Usage:
//   req carries one event request (init, deinit, mode request, bus-off, tick)
//   with its operands; rsp returns exactly one result per request: result code,
//   controller command, mode indications, bus state and attempt count.
//   The cfg_we/cfg_index/cfg_data port writes recovery_ticks (index 0) and
//   max_recovery_attempts (index 1); write them only while no request is open.
//   rsp.valid rises when the request moves through the event logic from the
//   input register into the result register. Throughput is one request per
//   cycle while the receiver holds rsp.ready high; the state registers update
//   when a request moves from the input register into the result register, so
//   the next request already sees the new state.
//   Reset clears both stages, the bus state (uninitialized), the recovery
//   timer and count, and loads recovery_ticks 10 and max_recovery_attempts 3.
//   When the receiver holds rsp.ready low, the result register holds its
//   request and the input register takes one more; req.ready then drops
//   until the result is taken.
`default_nettype none

`include "can_bus_state_manager_defines.svh"

module can_bus_state_manager
    import cbsm_pkg::*;
#(
    parameter int unsigned NUM_CONTROLLERS = cbsm_pkg::NUM_CONTROLLERS
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    cbsm_req_if.sink              req,
    cbsm_rsp_if.source            rsp,
    input  wire                   cfg_we,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data
);

    logic   in_valid_reg;
    req_t   in_data_reg;
    logic   out_valid_reg;
    rsp_t   out_data_reg;
    state_t state_reg;
    state_t state_next;
    cfg_t   cfg_reg;
    rsp_t   rsp_next;
    logic   out_free;
    logic   advance;
    logic   in_take;

    assign out_free = !out_valid_reg || rsp.ready;
    assign advance  = in_valid_reg && out_free;
    assign in_take  = req.valid && req.ready;

    assign req.ready   = !in_valid_reg || out_free;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_data_reg;

    cbsm_core #(
        .NUM_CONTROLLERS (NUM_CONTROLLERS)
    ) u_core (
        .req        (in_data_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .rsp        (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.recovery_ticks        <= RECOVERY_TICKS_RST;
            cfg_reg.max_recovery_attempts <= MAX_ATTEMPTS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RECOVERY_TICKS: cfg_reg.recovery_ticks        <= cfg_data[15:0];
                CFG_MAX_ATTEMPTS:   cfg_reg.max_recovery_attempts <= cfg_data[7:0];
                default:            cfg_reg                       <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= req.payload;
        end
        if (advance)
        begin
            out_data_reg <= rsp_next;
        end
    end

    `CBSM_ASSERT(a_uninit_state, clk, rst_n, !state_reg.initialized |-> (state_reg.bsm_state == ST_UNINIT))
    `CBSM_ASSERT(a_state_hold, clk, rst_n, !advance |=> $stable(state_reg))
    `CBSM_ASSERT(a_advance_fills_out, clk, rst_n, advance |=> out_valid_reg)
    `CBSM_ASSERT(a_ready_low_when_full, clk, rst_n, !req.ready |-> (in_valid_reg && out_valid_reg && !rsp.ready))
    `CBSM_ASSERT_NEVER(a_bad_state_code, clk, rst_n, state_reg.bsm_state > ST_RECOVERY)

endmodule

`default_nettype wire

// ===== rtl/cbsm_core.sv =====
// Next-state and result logic for one event of the CAN bus state manager.
// Purely combinational; depends on cbsm_pkg.
`default_nettype none

module cbsm_core
    import cbsm_pkg::*;
#(
    parameter int unsigned NUM_CONTROLLERS = cbsm_pkg::NUM_CONTROLLERS
)
(
    input  wire req_t   req,
    input  wire state_t state,
    input  wire cfg_t   cfg,
    output state_t      state_next,
    output rsp_t        rsp
);

    logic [15:0] timer_inc;
    logic [7:0]  count_inc;
    logic        ctrl_bad;

    assign timer_inc = (state.recovery_timer == TIMER_MAX) ? state.recovery_timer
                                                            : state.recovery_timer + 16'd1;
    assign count_inc = (state.recovery_count == COUNT_MAX) ? state.recovery_count
                                                            : state.recovery_count + 8'd1;
    assign ctrl_bad  = (req.controller_index >= 8'(NUM_CONTROLLERS));

    always_comb
    begin
        state_next                 = state;
        rsp.result_code            = RC_OK;
        rsp.controller_cmd         = CMD_NONE;
        rsp.link_indication        = LINK_NONE;
        rsp.manager_indication     = MGR_NONE;

        case (req.op)
            OP_INIT:
            begin
                state_next.initialized    = 1'b1;
                state_next.com_full       = 1'b0;
                state_next.busoff_pending = 1'b0;
                state_next.recovery_count = 8'd0;
                state_next.recovery_timer = 16'd0;
                state_next.bsm_state      = ST_NOCOM;
                rsp.controller_cmd        = CMD_STOP;
                rsp.link_indication       = LINK_STOPPED;
            end
            OP_DEINIT:
            begin
                if (!state.initialized)
                begin
                    rsp.result_code = RC_UNINIT;
                end
                else
                begin
                    state_next.initialized = 1'b0;
                    state_next.com_full    = 1'b0;
                    state_next.bsm_state   = ST_UNINIT;
                end
            end
            OP_MODE:
            begin
                if (!state.initialized)
                begin
                    rsp.result_code = RC_UNINIT;
                end
                else if (req.network_handle != 8'd0)
                begin
                    rsp.result_code = RC_BAD_NET;
                end
                else if (req.want_full)
                begin
                    rsp.controller_cmd = CMD_START;
                    if (!req.controller_ok)
                    begin
                        state_next.bsm_state = ST_NOCOM;
                        rsp.result_code      = RC_REFUSED;
                    end
                    else
                    begin
                        rsp.link_indication    = LINK_STARTED;
                        state_next.bsm_state   = ST_FULL;
                        state_next.com_full    = 1'b1;
                        rsp.manager_indication = MGR_FULL;
                    end
                end
                else
                begin
                    rsp.controller_cmd = CMD_STOP;
                    if (!req.controller_ok)
                    begin
                        state_next.bsm_state = ST_PRE_NOCOM;
                        rsp.result_code      = RC_REFUSED;
                    end
                    else
                    begin
                        rsp.link_indication    = LINK_STOPPED;
                        state_next.bsm_state   = ST_NOCOM;
                        state_next.com_full    = 1'b0;
                        rsp.manager_indication = MGR_NOCOM;
                    end
                end
            end
            OP_BUSOFF:
            begin
                if (!state.initialized)
                begin
                    rsp.result_code = RC_UNINIT;
                end
                else if (ctrl_bad)
                begin
                    rsp.result_code = RC_BAD_CTRL;
                end
                else
                begin
                    state_next.busoff_pending = 1'b1;
                    state_next.recovery_timer = 16'd0;
                    state_next.bsm_state      = ST_RECOVERY;
                    state_next.com_full       = 1'b0;
                    rsp.manager_indication    = MGR_NOCOM;
                end
            end
            OP_TICK:
            begin
                if (state.initialized && (state.bsm_state == ST_RECOVERY))
                begin
                    state_next.recovery_timer = timer_inc;
                    if (timer_inc >= cfg.recovery_ticks)
                    begin
                        state_next.recovery_count = count_inc;
                        // Too many attempts: give up quietly to no communication.
                        if (count_inc > cfg.max_recovery_attempts)
                        begin
                            state_next.bsm_state      = ST_NOCOM;
                            state_next.busoff_pending = 1'b0;
                            state_next.recovery_count = 8'd0;
                        end
                        else
                        begin
                            rsp.controller_cmd = CMD_STOP_START;
                            if (req.controller_ok)
                            begin
                                rsp.link_indication       = LINK_STARTED;
                                state_next.bsm_state      = ST_FULL;
                                state_next.com_full       = 1'b1;
                                state_next.busoff_pending = 1'b0;
                                state_next.recovery_count = 8'd0;
                                rsp.manager_indication    = MGR_FULL;
                            end
                            else
                            begin
                                state_next.recovery_timer = 16'd0;
                                rsp.result_code           = RC_REFUSED;
                            end
                        end
                    end
                end
            end
            default:
            begin
                // Unknown event kinds leave everything as it is.
            end
        endcase

        rsp.bus_state     = state_next.bsm_state;
        rsp.full_com      = state_next.com_full;
        rsp.attempt_count = state_next.recovery_count;
    end

endmodule

`default_nettype wire

// ===== test/cbsm_checker.sv =====
// Result checker for the CAN bus state manager: tracks register writes and accepted requests,
// predicts each result and compares it field by field. Depends on cbsm_pkg and both channel interfaces.
module cbsm_checker
    import cbsm_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    cbsm_req_if                  req,
    cbsm_rsp_if                  rsp,
    input  wire                  cfg_we,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_data,
    output int unsigned          fail_count,
    output int unsigned          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        mgr_initialized;
    logic [2:0]  mgr_state;
    logic        mgr_full;
    logic        busoff_pending;
    logic [15:0] recovery_timer;
    logic [7:0]  recovery_attempts;
    logic [15:0] cfg_recovery_ticks;
    logic [7:0]  cfg_max_attempts;

    rsp_t awaited_results [$];
    rsp_t oldest;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic compare_field(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
    endtask

    // Applies one request to the tracked manager state and returns the result it must produce.
    function automatic rsp_t bus_manager_response(input req_t ev);
        rsp_t r;
        r = '0;
        r.result_code        = RC_OK;
        r.controller_cmd     = CMD_NONE;
        r.link_indication    = LINK_NONE;
        r.manager_indication = MGR_NONE;
        case (ev.op)
            OP_INIT:
            begin
                mgr_initialized   = 1'b1;
                mgr_full          = 1'b0;
                busoff_pending    = 1'b0;
                recovery_attempts = '0;
                recovery_timer    = '0;
                mgr_state         = ST_NOCOM;
                r.controller_cmd  = CMD_STOP;
                r.link_indication = LINK_STOPPED;
            end
            OP_DEINIT:
            begin
                if (!mgr_initialized)
                    r.result_code = RC_UNINIT;
                else
                begin
                    // The bus-off bookkeeping survives a deinit.
                    mgr_initialized = 1'b0;
                    mgr_full        = 1'b0;
                    mgr_state       = ST_UNINIT;
                end
            end
            OP_MODE:
            begin
                if (!mgr_initialized)
                    r.result_code = RC_UNINIT;
                else if (ev.network_handle != 8'd0)
                    r.result_code = RC_BAD_NET;
                else if (ev.want_full)
                begin
                    r.controller_cmd = CMD_START;
                    if (!ev.controller_ok)
                    begin
                        mgr_state     = ST_NOCOM;
                        r.result_code = RC_REFUSED;
                    end
                    else
                    begin
                        mgr_state            = ST_FULL;
                        mgr_full             = 1'b1;
                        r.link_indication    = LINK_STARTED;
                        r.manager_indication = MGR_FULL;
                    end
                end
                else
                begin
                    r.controller_cmd = CMD_STOP;
                    if (!ev.controller_ok)
                    begin
                        mgr_state     = ST_PRE_NOCOM;
                        r.result_code = RC_REFUSED;
                    end
                    else
                    begin
                        mgr_state            = ST_NOCOM;
                        mgr_full             = 1'b0;
                        r.link_indication    = LINK_STOPPED;
                        r.manager_indication = MGR_NOCOM;
                    end
                end
            end
            OP_BUSOFF:
            begin
                if (!mgr_initialized)
                    r.result_code = RC_UNINIT;
                else if (ev.controller_index >= NUM_CONTROLLERS)
                    r.result_code = RC_BAD_CTRL;
                else
                begin
                    busoff_pending       = 1'b1;
                    recovery_timer       = '0;
                    mgr_state            = ST_RECOVERY;
                    mgr_full             = 1'b0;
                    r.manager_indication = MGR_NOCOM;
                end
            end
            OP_TICK:
            begin
                if (mgr_initialized && mgr_state == ST_RECOVERY)
                begin
                    if (recovery_timer != TIMER_MAX)
                        recovery_timer = recovery_timer + 16'd1;
                    if (recovery_timer >= cfg_recovery_ticks)
                    begin
                        if (recovery_attempts != COUNT_MAX)
                            recovery_attempts = recovery_attempts + 8'd1;
                        if (recovery_attempts > cfg_max_attempts)
                        begin
                            // Out of attempts: give up quietly.
                            mgr_state         = ST_NOCOM;
                            busoff_pending    = 1'b0;
                            recovery_attempts = '0;
                        end
                        else
                        begin
                            r.controller_cmd = CMD_STOP_START;
                            if (ev.controller_ok)
                            begin
                                mgr_state            = ST_FULL;
                                mgr_full             = 1'b1;
                                busoff_pending       = 1'b0;
                                recovery_attempts    = '0;
                                r.link_indication    = LINK_STARTED;
                                r.manager_indication = MGR_FULL;
                            end
                            else
                            begin
                                recovery_timer = '0;
                                r.result_code  = RC_REFUSED;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.bus_state     = mgr_state;
        r.full_com      = mgr_full;
        r.attempt_count = recovery_attempts;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mgr_initialized    = 1'b0;
            mgr_state          = ST_UNINIT;
            mgr_full           = 1'b0;
            busoff_pending     = 1'b0;
            recovery_timer     = '0;
            recovery_attempts  = '0;
            cfg_recovery_ticks = RECOVERY_TICKS_RST;
            cfg_max_attempts   = MAX_ATTEMPTS_RST;
            fail_count         = 0;
            awaited_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result arrived with no request waiting for it");
                else
                begin
                    oldest = awaited_results.pop_front();
                    compare_field("result_code", rsp.payload.result_code, oldest.result_code);
                    compare_field("bus_state", rsp.payload.bus_state, oldest.bus_state);
                    compare_field("full_com", rsp.payload.full_com, oldest.full_com);
                    compare_field("controller_cmd", rsp.payload.controller_cmd,
                                  oldest.controller_cmd);
                    compare_field("link_indication", rsp.payload.link_indication,
                                  oldest.link_indication);
                    compare_field("manager_indication", rsp.payload.manager_indication,
                                  oldest.manager_indication);
                    compare_field("attempt_count", rsp.payload.attempt_count,
                                  oldest.attempt_count);
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_RECOVERY_TICKS)
                    cfg_recovery_ticks = cfg_data[15:0];
                else if (cfg_index == CFG_MAX_ATTEMPTS)
                    cfg_max_attempts = cfg_data[7:0];
            end
            if (req.valid && req.ready)
                awaited_results.push_back(bus_manager_response(req.payload));
            outstanding <= awaited_results.size();
        end
    end
endmodule

// ===== test/tb_top.sv =====
// Testbench top for the CAN bus state manager: clock, reset, request and register stimulus,
// result back-pressure and the verdict. Depends on cbsm_pkg, the channel interfaces and cbsm_checker.
module tb_top
    import cbsm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Longest legal quiet stretch is a sender gap plus a receiver stall plus a register
    // write pause; this limit leaves wide margin.
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned SETTLE_CYCLES = 8;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned items_sent = 0;
    int unsigned idle_odds = 4;
    int unsigned quiet_cycles = 0;

    cbsm_req_if req_ch ();
    cbsm_rsp_if rsp_ch ();

    can_bus_state_manager u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cbsm_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    function automatic req_t make_event(input logic [2:0] op, input logic [7:0] net,
                                        input logic full, input logic [7:0] ctrl,
                                        input logic ok);
        req_t ev;
        ev.op               = op;
        ev.network_handle   = net;
        ev.want_full        = full;
        ev.controller_index = ctrl;
        ev.controller_ok    = ok;
        return ev;
    endfunction

    task automatic send_event(input req_t ev);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= ev;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
    endtask

    // Registers are only touched once every open request has produced its result.
    task automatic apply_settings(input logic [15:0] ticks, input logic [7:0] attempts);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RECOVERY_TICKS;
        cfg_data  <= ticks;
        @(posedge clk);
        cfg_index <= CFG_MAX_ATTEMPTS;
        cfg_data  <= {8'd0, attempts};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // A bus-off followed by ticks; one tick in ok_odds sees the restart accepted, none if 0.
    task automatic run_recovery(input int unsigned tick_count, input int unsigned ok_odds);
        int unsigned k;
        logic        ok;
        send_event(make_event(OP_BUSOFF, 8'($urandom), 1'($urandom), 8'd0, 1'($urandom)));
        for (k = 0; k < tick_count; k++)
        begin
            ok = (ok_odds != 0) && ($urandom_range(1, ok_odds) == 1);
            // Now and then a fresh bus-off or a mode request lands in the middle of recovery.
            if (ok_odds != 0 && $urandom_range(0, 31) == 0)
                send_event(make_event($urandom_range(0, 1) ? OP_BUSOFF : OP_MODE, 8'd0,
                                      1'($urandom), 8'($urandom_range(0, 1)), 1'($urandom)));
            send_event(make_event(OP_TICK, 8'($urandom), 1'($urandom), 8'($urandom), ok));
        end
    endtask

    task automatic random_phase(input int unsigned budget, input int unsigned ticks_cfg,
                                input int unsigned max_cfg);
        int unsigned start;
        int unsigned pick;
        int unsigned span;
        start = items_sent;
        // A phase with idling switched off keeps it off.
        if (idle_odds != 0)
        begin
            case ($urandom_range(0, 2))
                0: idle_odds = 2;
                1: idle_odds = 6;
                default: idle_odds = 20;
            endcase
        end
        while (items_sent - start < budget)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
                send_event(make_event(3'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                                      1'($urandom)));
            else if (pick == 2)
                send_event(make_event(OP_MODE,
                                      ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0,
                                      1'($urandom), 8'($urandom), 1'($urandom)));
            else
            begin
                if ($urandom_range(0, 1) == 1)
                    send_event(make_event(OP_INIT, 8'd0, 1'b0, 8'd0, 1'($urandom)));
                if ($urandom_range(0, 3) != 0)
                    send_event(make_event(OP_MODE, 8'd0, 1'b1, 8'd0, 1'b1));
                span = ticks_cfg * (max_cfg + 2) + 2;
                if (span > 40)
                    span = $urandom_range(5, 40);
                run_recovery(span, 4);
            end
        end
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin : sink_side
            int unsigned hold;
            hold = 0;
            forever
            begin
                @(posedge clk);
                if (!rst_n)
                    rsp_ch.ready <= 1'b0;
                else if (hold != 0)
                begin
                    hold--;
                    rsp_ch.ready <= 1'b0;
                end
                else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                begin
                    hold = $urandom_range(0, 5);
                    rsp_ch.ready <= 1'b0;
                end
                else
                    rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !(req_ch.valid && req_ch.ready) && !(rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAIL can_bus_state_manager");
                $finish;
            end
        end
        else
            quiet_cycles <= 0;
    end

    initial
    begin
        int unsigned n;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_RECOVERY_TICKS;
        cfg_data       = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests with the reset settings: each request kind before init,
        // unknown kinds, bad network and controller, each mode outcome, deinit in recovery.
        send_event(make_event(OP_TICK, 8'd0, 1'b0, 8'd0, 1'b1));
        send_event(make_event(OP_DEINIT, 8'd0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(OP_MODE, 8'd0, 1'b1, 8'd0, 1'b1));
        send_event(make_event(OP_BUSOFF, 8'd0, 1'b0, 8'd0, 1'b1));
        send_event(make_event(3'd5, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom)));
        send_event(make_event(3'd6, 8'd0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(3'd7, 8'hFF, 1'b1, 8'hFF, 1'b1));
        send_event(make_event(OP_INIT, 8'd0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(OP_INIT, 8'd0, 1'b0, 8'd0, 1'b1));
        send_event(make_event(OP_MODE, 8'hFF, 1'b1, 8'd0, 1'b1));
        send_event(make_event(OP_MODE, 8'd1, 1'b1, 8'd0, 1'b1));
        send_event(make_event(OP_MODE, 8'd0, 1'b1, 8'd0, 1'b0));
        send_event(make_event(OP_MODE, 8'd0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(OP_MODE, 8'd0, 1'b0, 8'd0, 1'b1));
        send_event(make_event(OP_MODE, 8'd0, 1'b1, 8'd0, 1'b1));
        send_event(make_event(OP_TICK, 8'd0, 1'b0, 8'd0, 1'b1));
        send_event(make_event(OP_BUSOFF, 8'd0, 1'b0, 8'hFF, 1'b0));
        send_event(make_event(OP_BUSOFF, 8'd0, 1'b0, 8'd1, 1'b0));
        send_event(make_event(OP_BUSOFF, 8'd0, 1'b0, 8'd0, 1'b0));
        repeat (3) send_event(make_event(OP_TICK, 8'd0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(OP_DEINIT, 8'd0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(OP_TICK, 8'd0, 1'b0, 8'd0, 1'b1));
        send_event(make_event(OP_INIT, 8'd0, 1'b0, 8'd0, 1'b0));
        random_phase(100, 10, 3);

        // Refused restart, then running out of attempts, then a successful restart.
        apply_settings(16'd1, 8'd1);
        send_event(make_event(OP_INIT, 8'd0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(OP_MODE, 8'd0, 1'b1, 8'd0, 1'b1));
        run_recovery(2, 0);
        run_recovery(0, 0);
        send_event(make_event(OP_TICK, 8'd0, 1'b0, 8'd0, 1'b1));
        random_phase(100, 1, 1);

        apply_settings(16'd1, 8'd0);
        random_phase(100, 1, 0);

        // A zero tick count restarts on every tick; with no attempt limit the count saturates.
        apply_settings(16'd0, 8'd255);
        send_event(make_event(OP_INIT, 8'd0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(OP_MODE, 8'd0, 1'b1, 8'd0, 1'b1));
        run_recovery(260, 0);
        send_event(make_event(OP_TICK, 8'd0, 1'b0, 8'd0, 1'b1));
        random_phase(80, 0, 255);

        apply_settings(16'd1, 8'd254);
        send_event(make_event(OP_INIT, 8'd0, 1'b0, 8'd0, 1'b0));
        run_recovery(256, 0);
        random_phase(80, 1, 254);

        for (n = 0; n < 3; n++)
        begin : mixed_settings
            int unsigned ticks;
            int unsigned attempts;
            ticks    = $urandom_range(1, 12);
            attempts = $urandom_range(0, 6);
            apply_settings(16'(ticks), 8'(attempts));
            random_phase(100, ticks, attempts);
        end

        // Closing stretch runs without any idling on either side.
        idle_odds = 0;
        apply_settings(16'd3, 8'd2);
        idle_odds = 0;
        random_phase(100, 3, 2);
        idle_odds = 0;
        apply_settings(16'hFFFF, 8'd1);
        send_event(make_event(OP_INIT, 8'd0, 1'b0, 8'd0, 1'b0));
        send_event(make_event(OP_MODE, 8'd0, 1'b1, 8'd0, 1'b1));
        run_recovery(20, 0);
        send_event(make_event(OP_TICK, 8'd0, 1'b0, 8'd0, 1'b1));

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS can_bus_state_manager");
        else
            $display("FAIL can_bus_state_manager");
        $finish;
    end
endmodule

// ===== can_bus_state_manager.f =====
+incdir+rtl
rtl/cbsm_pkg.sv
rtl/cbsm_req_if.sv
rtl/cbsm_rsp_if.sv
rtl/cbsm_core.sv
rtl/can_bus_state_manager.sv
test/cbsm_checker.sv
test/tb_top.sv
